@@ sv/rrab_pkg.sv @@
package rrab_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 24;
   localparam int PIX_BITS = 24;
   localparam int DIM_BITS = 12;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TINT_COLOR = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BLEND_ALPHA = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RECT_WIDTH = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RECT_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CORNER_RADIUS = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNEL_POSITIONS = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNEL_SIZES = 3'd6;

   localparam logic [23:0] TINT_RESET = 24'd0;
   localparam logic [6:0] PCT_FULL = 7'd100;
   localparam logic [14:0] POS_RESET = 15'd16640;
   localparam logic [11:0] SIZE_RESET = 12'd2184;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   // x / 100 == (x * 5243) >> 19, exact for x <= 25500
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int RECIP_SHIFT = 19;

   typedef struct packed {
      logic [23:0] tint_color;
      logic [6:0]  blend_alpha;
      logic [11:0] rect_width;
      logic [11:0] rect_height;
      logic [11:0] corner_radius;
      logic [14:0] channel_positions;
      logic [11:0] channel_sizes;
   } cfg_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   function automatic logic [3:0] size_clamp(input logic [3:0] size);
      return (size > 4'd8) ? 4'd8 : size;
   endfunction

   function automatic logic [7:0] chan_unpack(input logic [23:0] pix,
                                              input logic [4:0] pos,
                                              input logic [3:0] size);
      logic [3:0]  sz;
      logic [31:0] mask;
      logic [31:0] raw;
      logic [31:0] sh;
      sz = size_clamp(size);
      mask = (32'd1 << sz) - 32'd1;
      raw = ({8'd0, pix} >> pos) & mask;
      sh = raw << (4'd8 - sz);
      return sh[7:0];
   endfunction

   function automatic logic [23:0] chan_pack(input logic [7:0] v8,
                                             input logic [4:0] pos,
                                             input logic [3:0] size);
      logic [3:0]  sz;
      logic [39:0] v;
      sz = size_clamp(size);
      v = {32'd0, v8 >> (4'd8 - sz)} << pos;
      return v[23:0];
   endfunction

endpackage

@@ sv/rounded_rect_alpha_blend_pixel.sv @@
// An accepted req_ transaction moves through stages 1 to 4 to rsp_valid.
// Throughput: one transaction per cycle unless rsp_ready stalls; four-stage
// pipeline with per-stage valid bits, so bubbles close up under stalls.
// Reset (synchronous, active high): clears all valid bits and loads the
// configuration registers with their defaults.
module rounded_rect_alpha_blend_pixel #(
   parameter int COORD_BITS = rrab_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [COORD_BITS-1:0]                req_col_in_rect,
   input  logic [COORD_BITS-1:0]                req_row_in_rect,
   input  logic [rrab_pkg::PIX_BITS-1:0]        req_background_pixel,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_write_enable,
   output logic [rrab_pkg::PIX_BITS-1:0]        rsp_blended_pixel,

   input  logic                                 csr_write_enable,
   input  logic [rrab_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rrab_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   rrab_pkg::cfg_type      cfg;
   rrab_pkg::stage_en_type en;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic in_shape;
   logic [rrab_pkg::PIX_BITS-1:0] packed_pixel;

   rrab_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   always_comb begin
      en.s4 = !v4_ff || rsp_ready;
      en.s3 = !v3_ff || en.s4;
      en.s2 = !v2_ff || en.s3;
      en.s1 = !v1_ff || en.s2;
      v1_in = en.s1 ? req_valid : v1_ff;
      v2_in = en.s2 ? v1_ff : v2_ff;
      v3_in = en.s3 ? v2_ff : v3_ff;
      v4_in = en.s4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   rrab_shape #(
      .COORD_BITS (COORD_BITS)
   ) u_shape (
      .clock    (clock),
      .en       (en),
      .cfg      (cfg),
      .col      (req_col_in_rect),
      .row      (req_row_in_rect),
      .in_shape (in_shape)
   );

   rrab_blend u_blend (
      .clock            (clock),
      .en               (en),
      .cfg              (cfg),
      .background_pixel (req_background_pixel),
      .packed_pixel     (packed_pixel)
   );

   assign req_ready = en.s1;
   assign rsp_valid = v4_ff;
   assign rsp_write_enable = in_shape;
   assign rsp_blended_pixel = in_shape ? packed_pixel : '0;

endmodule

@@ sv/rrab_csr.sv @@
module rrab_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [rrab_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rrab_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output rrab_pkg::cfg_type                    cfg
);

   rrab_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rrab_pkg::REG_TINT_COLOR: cfg_in.tint_color = csr_write_data[23:0];
            rrab_pkg::REG_BLEND_ALPHA: begin
               cfg_in.blend_alpha = (csr_write_data[6:0] > rrab_pkg::PCT_FULL) ?
                                    rrab_pkg::PCT_FULL : csr_write_data[6:0];
            end
            rrab_pkg::REG_RECT_WIDTH: cfg_in.rect_width = csr_write_data[11:0];
            rrab_pkg::REG_RECT_HEIGHT: cfg_in.rect_height = csr_write_data[11:0];
            rrab_pkg::REG_CORNER_RADIUS: cfg_in.corner_radius = csr_write_data[11:0];
            rrab_pkg::REG_CHANNEL_POSITIONS: begin
               cfg_in.channel_positions = csr_write_data[14:0];
            end
            rrab_pkg::REG_CHANNEL_SIZES: cfg_in.channel_sizes = csr_write_data[11:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tint_color <= rrab_pkg::TINT_RESET;
         cfg_ff.blend_alpha <= rrab_pkg::PCT_FULL;
         cfg_ff.rect_width <= '0;
         cfg_ff.rect_height <= '0;
         cfg_ff.corner_radius <= '0;
         cfg_ff.channel_positions <= rrab_pkg::POS_RESET;
         cfg_ff.channel_sizes <= rrab_pkg::SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/rrab_shape.sv @@
module rrab_shape #(
   parameter int COORD_BITS = rrab_pkg::COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  rrab_pkg::stage_en_type  en,
   input  rrab_pkg::cfg_type       cfg,
   input  logic [COORD_BITS-1:0]   col,
   input  logic [COORD_BITS-1:0]   row,
   output logic                    in_shape
);

   localparam int CW = COORD_BITS;
   localparam int SW = 2 * CW;

   logic [CW-1:0] w, h, r0, ra, rb;

   logic [CW-1:0] col1_ff, row1_ff, r1_ff;
   logic          outside1_ff, outside1_in;

   logic [CW-1:0] wr, hr, dx2_in, dy2_in;
   logic          left, right, top, bottom, corner2_in;
   logic [CW-1:0] dx2_ff, dy2_ff, r2_ff;
   logic          corner2_ff, outside2_ff;

   logic [SW-1:0] dxsq3_ff, dysq3_ff, rsq3_ff;
   logic          corner3_ff, outside3_ff;

   logic [SW:0]   dsq_sum;
   logic          inside4_ff, inside4_in;

   // stage 1: clamp radius, rectangle bounds
   always_comb begin
      w = CW'(cfg.rect_width);
      h = CW'(cfg.rect_height);
      r0 = CW'(cfg.corner_radius);
      ra = ({r0, 1'b0} > {1'b0, w}) ? (w >> 1) : r0;
      rb = ({ra, 1'b0} > {1'b0, h}) ? (h >> 1) : ra;
      outside1_in = (col >= w) || (row >= h);
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         col1_ff <= col;
         row1_ff <= row;
         r1_ff <= rb;
         outside1_ff <= outside1_in;
      end
   end

   // stage 2: corner region and distance to corner center
   always_comb begin
      wr = w - r1_ff;
      hr = h - r1_ff;
      left = col1_ff < r1_ff;
      right = col1_ff >= wr;
      top = row1_ff < r1_ff;
      bottom = row1_ff >= hr;
      corner2_in = (left || right) && (top || bottom);
      dx2_in = left ? (r1_ff - col1_ff) : (col1_ff - wr);
      dy2_in = top ? (r1_ff - row1_ff) : (row1_ff - hr);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         dx2_ff <= dx2_in;
         dy2_ff <= dy2_in;
         r2_ff <= r1_ff;
         corner2_ff <= corner2_in;
         outside2_ff <= outside1_ff;
      end
   end

   // stage 3: squares
   always_ff @(posedge clock) begin
      if (en.s3) begin
         dxsq3_ff <= SW'(dx2_ff) * SW'(dx2_ff);
         dysq3_ff <= SW'(dy2_ff) * SW'(dy2_ff);
         rsq3_ff <= SW'(r2_ff) * SW'(r2_ff);
         corner3_ff <= corner2_ff;
         outside3_ff <= outside2_ff;
      end
   end

   // stage 4: radius test
   always_comb begin
      dsq_sum = (SW + 1)'(dxsq3_ff) + (SW + 1)'(dysq3_ff);
      inside4_in = !outside3_ff && (!corner3_ff || (dsq_sum <= (SW + 1)'(rsq3_ff)));
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         inside4_ff <= inside4_in;
      end
   end

   assign in_shape = inside4_ff;

endmodule

@@ sv/rrab_blend.sv @@
module rrab_blend (
   input  logic                    clock,
   input  rrab_pkg::stage_en_type  en,
   input  rrab_pkg::cfg_type       cfg,
   input  logic [23:0]             background_pixel,
   output logic [23:0]             packed_pixel
);

   logic [4:0]  pr, pg, pb;
   logic [3:0]  sr, sg, sb;
   logic [7:0]  tr, tg, tb;
   logic [6:0]  inv_a;

   logic [7:0]  br1_ff, bg1_ff, bb1_ff;
   logic [14:0] sumr2_ff, sumg2_ff, sumb2_ff;
   logic [27:0] prodr3_ff, prodg3_ff, prodb3_ff;
   logic [7:0]  qr, qg, qb;
   logic [23:0] pack4_ff, pack4_in;

   always_comb begin
      pr = cfg.channel_positions[14:10];
      pg = cfg.channel_positions[9:5];
      pb = cfg.channel_positions[4:0];
      sr = cfg.channel_sizes[11:8];
      sg = cfg.channel_sizes[7:4];
      sb = cfg.channel_sizes[3:0];
      tr = cfg.tint_color[23:16];
      tg = cfg.tint_color[15:8];
      tb = cfg.tint_color[7:0];
      inv_a = rrab_pkg::PCT_FULL - cfg.blend_alpha;
   end

   // stage 1: unpack
   always_ff @(posedge clock) begin
      if (en.s1) begin
         br1_ff <= rrab_pkg::chan_unpack(background_pixel, pr, sr);
         bg1_ff <= rrab_pkg::chan_unpack(background_pixel, pg, sg);
         bb1_ff <= rrab_pkg::chan_unpack(background_pixel, pb, sb);
      end
   end

   // stage 2: weighted sum
   always_ff @(posedge clock) begin
      if (en.s2) begin
         sumr2_ff <= 15'(br1_ff) * 15'(inv_a) + 15'(tr) * 15'(cfg.blend_alpha);
         sumg2_ff <= 15'(bg1_ff) * 15'(inv_a) + 15'(tg) * 15'(cfg.blend_alpha);
         sumb2_ff <= 15'(bb1_ff) * 15'(inv_a) + 15'(tb) * 15'(cfg.blend_alpha);
      end
   end

   // stage 3: divide by 100 via reciprocal
   always_ff @(posedge clock) begin
      if (en.s3) begin
         prodr3_ff <= 28'(sumr2_ff) * 28'(rrab_pkg::RECIP_100);
         prodg3_ff <= 28'(sumg2_ff) * 28'(rrab_pkg::RECIP_100);
         prodb3_ff <= 28'(sumb2_ff) * 28'(rrab_pkg::RECIP_100);
      end
   end

   // stage 4: repack
   always_comb begin
      qr = prodr3_ff[rrab_pkg::RECIP_SHIFT +: 8];
      qg = prodg3_ff[rrab_pkg::RECIP_SHIFT +: 8];
      qb = prodb3_ff[rrab_pkg::RECIP_SHIFT +: 8];
      pack4_in = rrab_pkg::chan_pack(qr, pr, sr) |
                 rrab_pkg::chan_pack(qg, pg, sg) |
                 rrab_pkg::chan_pack(qb, pb, sb);
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         pack4_ff <= pack4_in;
      end
   end

   assign packed_pixel = pack4_ff;

endmodule
